FILE: rtl/aorl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aorl_pkg
// Shared widths, codes and types of the age ordered request latch.
// ----------------------------------------------------------------------------
package aorl_pkg;

  localparam int MAX_BUTTONS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic             fire;
    logic             known;
    logic [CMD_W-1:0] cmd;
  } upd_t;

  typedef struct packed {
    logic             any_lit;
    logic             oldest_valid;
    logic [IDX_W-1:0] oldest_index;
  } oldest_t;

  typedef struct packed {
    logic             named_lit;
    logic             any_lit;
    logic             oldest_valid;
    logic [IDX_W-1:0] oldest_index;
    logic             index_known;
  } res_t;

endpackage

FILE: rtl/aorl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aorl_in_if
// Request channel: command and button index with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aorl_in_if;
  logic                       valid;
  logic                       ready;
  logic [aorl_pkg::CMD_W-1:0] cmd;
  logic [aorl_pkg::IDX_W-1:0] button_index;

  modport source (output valid, output cmd, output button_index, input ready);
  modport sink   (input valid, input cmd, input button_index, output ready);
endinterface

FILE: rtl/aorl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aorl_out_if
// Result channel: button status and oldest lit button with valid/ready.
// ----------------------------------------------------------------------------
interface aorl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       named_lit;
  logic                       any_lit;
  logic                       oldest_valid;
  logic [aorl_pkg::IDX_W-1:0] oldest_index;
  logic                       index_known;

  modport source (output valid, output named_lit, output any_lit, output oldest_valid,
                  output oldest_index, output index_known, input ready);
  modport sink   (input valid, input named_lit, input any_lit, input oldest_valid,
                  input oldest_index, input index_known, output ready);
endinterface

FILE: rtl/age_ordered_request_latch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_ordered_request_latch
// Request buttons with lit flags and press ranks; reports the oldest lit one.
//
//   Channel  Direction  Handshake            Payload
//   in_ch    input      valid / ready        cmd, button_index
//   out_ch   output     valid / ready        named_lit, any_lit, oldest_valid,
//                                            oldest_index, index_known
//   cfg_*    input      cfg_valid/cfg_ready  cfg_button_count
//
// One request is taken every cycle unless the result stalls; the input
// register loads at the transfer edge, the shown result register on advance.
// Reset clears all flags, ranks and the lit count and sets the count to 16.
// A stalled result holds the result register, which in turn holds the input
// register; the configuration port is always ready.
// ----------------------------------------------------------------------------
module age_ordered_request_latch #(
  parameter int MAX_BUTTONS = aorl_pkg::MAX_BUTTONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  aorl_in_if.sink                      in_ch,
  aorl_out_if.source                   out_ch,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aorl_pkg::COUNT_W-1:0] cfg_button_count
);

  localparam int RANK_W = $clog2(MAX_BUTTONS);

  logic                               s0_valid_r;
  aorl_pkg::req_t                     s0_req_r;
  logic [aorl_pkg::COUNT_W-1:0]       count_r;
  logic                               out_valid_r;
  aorl_pkg::res_t                     res_r, res_nxt;

  logic                               advance;
  logic                               known;
  logic [MAX_BUTTONS-1:0]             sel;
  aorl_pkg::upd_t                     upd;
  logic [MAX_BUTTONS-1:0]             lit_view;
  logic [MAX_BUTTONS-1:0][RANK_W-1:0] rank_view;
  aorl_pkg::oldest_t                  oldest;

  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || advance;
  assign cfg_ready   = 1'b1;

  assign known = ({1'b0, s0_req_r.idx} < count_r) && (32'(s0_req_r.idx) < MAX_BUTTONS);

  always_comb begin
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      sel[i] = (32'(s0_req_r.idx) == i);
    end
  end

  assign upd.fire  = advance;
  assign upd.known = known;
  assign upd.cmd   = s0_req_r.cmd;

  aorl_rank_table #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .sel       (sel),
    .lit_view  (lit_view),
    .rank_view (rank_view)
  );

  aorl_oldest_sel #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_oldest (
    .lit    (lit_view),
    .rank   (rank_view),
    .oldest (oldest)
  );

  always_comb begin
    res_nxt.named_lit    = known && |(sel & lit_view);
    res_nxt.any_lit      = oldest.any_lit;
    res_nxt.oldest_valid = oldest.oldest_valid;
    res_nxt.oldest_index = oldest.oldest_index;
    res_nxt.index_known  = known;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= aorl_pkg::COUNT_RESET;
    end else begin
      if (in_ch.ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        count_r <= cfg_button_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_req_r.cmd <= in_ch.cmd;
      s0_req_r.idx <= in_ch.button_index;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.named_lit    = res_r.named_lit;
  assign out_ch.any_lit      = res_r.any_lit;
  assign out_ch.oldest_valid = res_r.oldest_valid;
  assign out_ch.oldest_index = res_r.oldest_index;
  assign out_ch.index_known  = res_r.index_known;

  a_oldest_iff_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.oldest_valid == res_r.any_lit))
    else $error("oldest button flag disagrees with the any-lit flag");

  a_named_needs_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.named_lit) |-> res_r.index_known)
    else $error("named button reported lit while out of range");

  a_no_oldest_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.oldest_valid) |-> (res_r.oldest_index == '0))
    else $error("oldest index is not zero while no button is lit");

endmodule

FILE: rtl/aorl_rank_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aorl_rank_table
// Lit flags and press ranks of all buttons, updated by one press or clear.
// ----------------------------------------------------------------------------
module aorl_rank_table #(
  parameter int MAX_BUTTONS = aorl_pkg::MAX_BUTTONS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  aorl_pkg::upd_t                              upd,
  input  logic [MAX_BUTTONS-1:0]                      sel,
  output logic [MAX_BUTTONS-1:0]                      lit_view,
  output logic [MAX_BUTTONS-1:0][$clog2(MAX_BUTTONS)-1:0] rank_view
);

  localparam int RANK_W = $clog2(MAX_BUTTONS);
  localparam int TOT_W  = $clog2(MAX_BUTTONS + 1);

  logic [MAX_BUTTONS-1:0]             lit_r, lit_nxt;
  logic [MAX_BUTTONS-1:0][RANK_W-1:0] rank_r, rank_nxt;
  logic [TOT_W-1:0]                   total_r, total_nxt;
  logic [RANK_W-1:0]                  gone;
  logic                               hit_lit;

  assign hit_lit = |(sel & lit_r);

  always_comb begin
    gone = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (sel[i]) begin
        gone = gone | rank_r[i];
      end
    end
  end

  always_comb begin
    lit_nxt   = lit_r;
    rank_nxt  = rank_r;
    total_nxt = total_r;
    if (upd.fire && upd.known) begin
      if (upd.cmd == aorl_pkg::CMD_PRESS && !hit_lit) begin
        for (int i = 0; i < MAX_BUTTONS; i++) begin
          if (sel[i]) begin
            lit_nxt[i]  = 1'b1;
            rank_nxt[i] = RANK_W'(total_r);
          end
        end
        total_nxt = total_r + 1'b1;
      end else if (upd.cmd == aorl_pkg::CMD_CLEAR && hit_lit) begin
        for (int i = 0; i < MAX_BUTTONS; i++) begin
          if (sel[i]) begin
            lit_nxt[i]  = 1'b0;
            rank_nxt[i] = '0;
          end else if (lit_r[i] && rank_r[i] > gone) begin
            rank_nxt[i] = rank_r[i] - 1'b1;
          end
        end
        total_nxt = total_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= '0;
      rank_r  <= '0;
      total_r <= '0;
    end else begin
      lit_r   <= lit_nxt;
      rank_r  <= rank_nxt;
      total_r <= total_nxt;
    end
  end

  assign lit_view  = lit_nxt;
  assign rank_view = rank_nxt;

  a_total_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == TOT_W'($countones(lit_r)))
    else $error("lit count does not match the lit flags");

  a_clear_drops_total: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.fire && upd.known && upd.cmd == aorl_pkg::CMD_CLEAR && hit_lit)
    |=> total_r == $past(total_r) - 1'b1)
    else $error("clear of a lit button did not lower the lit count");

  a_press_raises_total: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.fire && upd.known && upd.cmd == aorl_pkg::CMD_PRESS && !hit_lit)
    |=> total_r == $past(total_r) + 1'b1)
    else $error("press of an unlit button did not raise the lit count");

endmodule

FILE: rtl/aorl_oldest_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aorl_oldest_sel
// Finds whether any button is lit and which lit button holds rank zero.
// ----------------------------------------------------------------------------
module aorl_oldest_sel #(
  parameter int MAX_BUTTONS = aorl_pkg::MAX_BUTTONS_DEF
) (
  input  logic [MAX_BUTTONS-1:0]                          lit,
  input  logic [MAX_BUTTONS-1:0][$clog2(MAX_BUTTONS)-1:0] rank,
  output aorl_pkg::oldest_t                               oldest
);

  localparam int IW = aorl_pkg::IDX_W;

  always_comb begin
    oldest.any_lit      = |lit;
    oldest.oldest_valid = 1'b0;
    oldest.oldest_index = '0;
    for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
      if (lit[i] && rank[i] == '0) begin
        oldest.oldest_valid = 1'b1;
        oldest.oldest_index = IW'(i);
      end
    end
  end

endmodule
